@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file spq_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spq assertion failed");

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spq assertion failed");

`endif

@@ hw/rtl/spq_pkg.sv @@
// Package for the sorted priority queue: widths, codes, payload structs.
// No dependencies.
package spq_pkg;

   localparam int KEY_W        = 32;
   localparam int OCC_W        = 5;
   localparam int STATUS_W     = 2;
   localparam int CAPACITY_DEF = 16;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic                    req_type;
      logic signed [KEY_W-1:0] key_value;
   } req_data_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] out_key;
      logic                    out_valid;
      logic [STATUS_W-1:0]     status;
      logic [OCC_W-1:0]        occupancy;
   } rsp_data_type;

   // broadcast to every cell
   typedef struct packed {
      logic enq;
      logic deq;
   } cell_cmd_type;

   // what a cell shows its right-hand neighbor
   typedef struct packed {
      logic occupied;
      logic greater;
   } cell_link_type;

endpackage

@@ hw/rtl/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: a chain of spq_cell slots and
// the occupancy counter. Uses spq_pkg and spq_cell.
//
//   port group   direction   handshake           payload
//   req_         in          start / busy        req_data  (spq_pkg::req_data_type)
//   rsp_         out         rsp_valid strobe    rsp_data  (spq_pkg::rsp_data_type)
//
// One transaction per cycle; its result strobes the cycle after it is taken.
// Every cell compares against the new key in parallel, so insert and remove
// each update the whole chain at once, regardless of CAPACITY.
// busy is high during reset and the cycle after; otherwise low.
// The receiver cannot stall: each result shows for exactly one cycle.
module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  spq_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   output spq_pkg::rsp_data_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    busy_ff;
   logic                    rsp_valid_ff;
   spq_pkg::rsp_data_type   rsp_data_ff;
   spq_pkg::rsp_data_type   rsp_data_in;

   logic                    accept;
   logic                    is_deq;
   logic                    empty;
   logic                    full;
   spq_pkg::cell_cmd_type   cmd;

   logic signed [spq_pkg::KEY_W-1:0] cell_key [CAPACITY];
   spq_pkg::cell_link_type           cell_link [CAPACITY];

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign accept  = start && !busy_ff;
   assign is_deq  = (req_data.req_type == spq_pkg::OP_DEQUEUE);
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign cmd.enq = accept && !is_deq && !full;
   assign cmd.deq = accept && is_deq && !empty;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [spq_pkg::KEY_W-1:0] prev_key;
      logic signed [spq_pkg::KEY_W-1:0] next_key;
      spq_pkg::cell_link_type           prev_link;

      if (i == 0) begin : g_head
         // head sees an occupied, never-greater left edge
         assign prev_key  = req_data.key_value;
         assign prev_link = '{occupied: 1'b1, greater: 1'b0};
      end else begin : g_body
         assign prev_key  = cell_key[i-1];
         assign prev_link = cell_link[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_key = '0;
      end else begin : g_inner
         assign next_key = cell_key[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .new_key   (req_data.key_value),
         .occupied  (CNT_W'(i) < count_ff),
         .prev_key  (prev_key),
         .prev_link (prev_link),
         .next_key  (next_key),
         .key       (cell_key[i]),
         .link      (cell_link[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.enq) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.deq) begin
         count_in = count_ff - CNT_W'(1);
      end

      rsp_data_in.out_key   = cmd.deq ? cell_key[0] : '0;
      rsp_data_in.out_valid = cmd.deq;
      rsp_data_in.occupancy = spq_pkg::OCC_W'(count_in);
      priority if (is_deq && empty) begin
         rsp_data_in.status = spq_pkg::STATUS_EMPTY;
      end else if (!is_deq && full) begin
         rsp_data_in.status = spq_pkg::STATUS_FULL;
      end else begin
         rsp_data_in.status = spq_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ hw/rtl/spq_cell.sv @@
// One slot of the sorted register chain: holds a key, compares it with the
// incoming key and shifts right on insert or left on removal. Uses spq_pkg.
module spq_cell (
   input  logic                            clock,
   input  spq_pkg::cell_cmd_type           cmd,
   input  logic signed [spq_pkg::KEY_W-1:0] new_key,
   input  logic                            occupied,
   input  logic signed [spq_pkg::KEY_W-1:0] prev_key,
   input  spq_pkg::cell_link_type          prev_link,
   input  logic signed [spq_pkg::KEY_W-1:0] next_key,
   output logic signed [spq_pkg::KEY_W-1:0] key,
   output spq_pkg::cell_link_type          link
);

   logic signed [spq_pkg::KEY_W-1:0] key_ff;
   logic signed [spq_pkg::KEY_W-1:0] key_in;

   assign key           = key_ff;
   assign link.occupied = occupied;
   assign link.greater  = occupied && (key_ff > new_key);

   always_comb begin
      key_in = key_ff;
      priority if (cmd.deq) begin
         key_in = next_key;
      end else if (cmd.enq) begin
         // take the left neighbor's key if it shifts in, else the new key if it lands here
         priority if (prev_link.greater) begin
            key_in = prev_key;
         end else if (link.greater || (!occupied && prev_link.occupied)) begin
            key_in = new_key;
         end else begin
            key_in = key_ff;
         end
      end else begin
         key_in = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

@@ hw/rtl/spq_checker.sv @@
// Port-level checks for sorted_priority_queue, bound to the top level.
// Uses spq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spq_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input spq_pkg::req_data_type req_data,
   input logic                  rsp_valid,
   input spq_pkg::rsp_data_type rsp_data
);

   logic accept;
   logic deq_result;
   logic empty_result;
   logic is_deq_req;
   logic rsp_ok;
   logic empty_fields;

   assign accept       = start && !busy;
   assign deq_result   = rsp_valid && rsp_data.out_valid;
   assign empty_result = rsp_valid && (rsp_data.status == spq_pkg::STATUS_EMPTY);
   assign is_deq_req   = (req_data.req_type == spq_pkg::OP_DEQUEUE);
   assign rsp_ok       = (rsp_data.status == spq_pkg::STATUS_OK);
   assign empty_fields = (rsp_data.occupancy == '0) && !rsp_data.out_valid
                         && (rsp_data.out_key == '0);

   `SPQ_ASSERT_NXT(a_rsp_follows_req, clock, reset, accept, rsp_valid)
   `SPQ_ASSERT_IMP(a_rsp_has_req, clock, reset, rsp_valid, $past(accept))
   `SPQ_ASSERT_IMP(a_key_from_deq, clock, reset, deq_result, $past(is_deq_req) && rsp_ok)
   `SPQ_ASSERT_IMP(a_empty_result, clock, reset, empty_result, empty_fields)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
